[rtl/lmms_pkg.sv]
// ----------------------------------------------------------------------------
// lmms_pkg
// Shared types, constants and the exp(-dE) table builder for the lattice
// Metropolis move engine.
// ----------------------------------------------------------------------------
package lmms_pkg;

  localparam int LATTICE_SIDE_DEF    = 128;
  localparam int MAX_ELEMENTS_DEF    = 1024;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam int POS_W      = 7;
  localparam int IDX_W      = 10;
  localparam int RND_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int DE_W       = 15;
  localparam int CNT_W      = 11;
  localparam int OWN_W      = 11;
  localparam int KIND_W     = 2;
  localparam int CE_W       = 6;
  localparam int MBE_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int STEP_W     = 4;
  localparam int P_W        = 17;

  localparam logic [CNT_W-1:0] MOLECULE_COUNT_RST = 11'd200;
  localparam logic [CNT_W-1:0] METAL_COUNT_RST    = 11'd400;
  localparam logic [CE_W-1:0]  COORD_ENERGY_RST   = 6'd10;
  localparam logic [MBE_W-1:0] MOL_BOND_RST       = 10'd48;
  localparam logic [CE_W-1:0]  METAL_BOND_RST     = 6'd10;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  // footprint directions: up (-x), right (+y), down (+x), left (-y), centre
  localparam logic [2:0] DIR_UP     = 3'd0;
  localparam logic [2:0] DIR_RIGHT  = 3'd1;
  localparam logic [2:0] DIR_DOWN   = 3'd2;
  localparam logic [2:0] DIR_LEFT   = 3'd3;
  localparam logic [2:0] DIR_CENTRE = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED, ST_OCCUPIED, ST_MOVED, ST_REJECTED, ST_BAD_INDEX
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    SK_EMPTY, SK_METAL, SK_ARM, SK_CENTRE
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOLECULE_COUNT, CFG_METAL_COUNT, CFG_COORD_ENERGY, CFG_MOL_BOND, CFG_METAL_BOND
  } cfg_reg_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LATCH, DP_WRAP, DP_CLEAR, DP_OCC_RD, DP_PLACE_WR,
    DP_CTR_RD, DP_EN_RD, DP_CLR_OLD, DP_WR_NEW, DP_RESULT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRAP, S_CHECK, S_OCC, S_OCC_WAIT, S_OCC_DEC, S_PLACE,
    S_CTR, S_EN, S_EN_WAIT, S_DEC, S_CLR_OLD, S_WR_NEW, S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t              op;
    logic [STEP_W-1:0]   step;
    status_t             res;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic wrap_done;
    logic bad;
    logic mol;
    logic mode;
    logic busy;
    logic take;
  } dp_stat_t;

  // exp(-k/16) in Q0.16, built at elaboration
  function automatic logic [P_W-1:0] exp_q16(input int k);
    logic [63:0] v;
    v = 64'h1_0000_0000;
    if (k == 0) return P_W'(65535);
    for (int i = 1; i <= k; i++) v = (v * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    return P_W'((v + 64'd32768) >> 16);
  endfunction

endpackage

[rtl/lmms_item_if.sv]
// ----------------------------------------------------------------------------
// lmms_item_if
// Input item channel: mode, element, candidate centre and random draw.
// ----------------------------------------------------------------------------
interface lmms_item_if;
  import lmms_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_W-1:0]    element_index;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [RND_W-1:0]    random_value;
  modport source (output valid, mode, element_index, pos_x, pos_y, random_value,
                  input ready);
  modport sink (input valid, mode, element_index, pos_x, pos_y, random_value,
                output ready);
endinterface

[rtl/lmms_result_if.sv]
// ----------------------------------------------------------------------------
// lmms_result_if
// Result item channel: status code and energy change.
// ----------------------------------------------------------------------------
interface lmms_result_if;
  import lmms_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic signed [DE_W-1:0] delta_energy;
  modport source (output valid, status, delta_energy, input ready);
  modport sink (input valid, status, delta_energy, output ready);
endinterface

[rtl/lmms_cfg_if.sv]
// ----------------------------------------------------------------------------
// lmms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lmms_cfg_if;
  import lmms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/lattice_metropolis_move_step.sv]
// ----------------------------------------------------------------------------
// lattice_metropolis_move_step
// Lattice-gas Metropolis move engine: places and moves cross-shaped molecules
// and single-site metals on a periodic square lattice.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : one item = mode, element_index, pos_x, pos_y, random_value.
//   out_ch : one result item per input item = status, delta_energy.
//   cfg_ch : register writes (index, data); always ready, write only when idle.
//   After reset the site memory is swept clean, one site a cycle, with in_ready
//   low throughout; config writes are taken during the sweep.
//   An item ends as a bad index, an occupied footprint (metal or molecule),
//   a placement, or a move (rejected or taken), with coordinate wrap steps
//   added when LATTICE_SIDE is below 128. The next item can be taken in the
//   cycle the result is raised. The steps are set by the site memory: each
//   footprint site and each of the sixteen neighbour sites is one read or
//   write.
//   One item at a time; the result sits in an output register, so the next
//   item is taken while it waits. If the receiver stalls, the following
//   item stops at its end until the output register frees up.
// ----------------------------------------------------------------------------
module lattice_metropolis_move_step #(
  parameter int LATTICE_SIDE    = lmms_pkg::LATTICE_SIDE_DEF,
  parameter int MAX_ELEMENTS    = lmms_pkg::MAX_ELEMENTS_DEF,
  parameter int EXP_TABLE_DEPTH = lmms_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  lmms_item_if.sink      in_ch,
  lmms_result_if.source  out_ch,
  lmms_cfg_if.sink       cfg_ch
);
  import lmms_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config writes are always accepted
  assign cfg_ch.ready = 1'b1;

  lmms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lmms_dp #(
    .LATTICE_SIDE    (LATTICE_SIDE),
    .MAX_ELEMENTS    (MAX_ELEMENTS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_ch.mode),
    .in_element_index (in_ch.element_index),
    .in_pos_x         (in_ch.pos_x),
    .in_pos_y         (in_ch.pos_y),
    .in_random_value  (in_ch.random_value),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_status       (out_ch.status),
    .out_delta_energy (out_ch.delta_energy)
  );

  // clearing sweep follows reset: no item taken straight after
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ch.ready)
    else $error("item taken during clearing sweep");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item taken while busy");

  // only moves carry an energy change
  a_zero_de: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_MOVED && out_ch.status != ST_REJECTED
      |-> out_ch.delta_energy == '0)
    else $error("non-move result with energy change");

  // result only raised from the end of an item in work
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("result raised with no item in work");
endmodule

[rtl/lmms_ram.sv]
// ----------------------------------------------------------------------------
// lmms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/lmms_dp.sv]
// ----------------------------------------------------------------------------
// lmms_dp
// Datapath: item fields, config registers, site and centre memories,
// footprint addressing, energy accumulation and acceptance test.
// ----------------------------------------------------------------------------
module lmms_dp #(
  parameter int LATTICE_SIDE    = lmms_pkg::LATTICE_SIDE_DEF,
  parameter int MAX_ELEMENTS    = lmms_pkg::MAX_ELEMENTS_DEF,
  parameter int EXP_TABLE_DEPTH = lmms_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lmms_pkg::dp_cmd_t                    cmd,
  output lmms_pkg::dp_stat_t                   stat,
  input  logic                                 in_mode,
  input  logic [lmms_pkg::IDX_W-1:0]           in_element_index,
  input  logic [lmms_pkg::POS_W-1:0]           in_pos_x,
  input  logic [lmms_pkg::POS_W-1:0]           in_pos_y,
  input  logic [lmms_pkg::RND_W-1:0]           in_random_value,
  input  logic                                 cfg_we,
  input  logic [lmms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lmms_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [lmms_pkg::STATUS_W-1:0]        out_status,
  output logic signed [lmms_pkg::DE_W-1:0]     out_delta_energy
);
  import lmms_pkg::*;

  localparam int CW     = $clog2(LATTICE_SIDE);
  localparam int CW1    = CW + 1;
  localparam int NSITES = LATTICE_SIDE * LATTICE_SIDE;
  localparam int AW     = $clog2(NSITES);
  localparam int EW     = $clog2(MAX_ELEMENTS);
  localparam int TW     = $clog2(EXP_TABLE_DEPTH);
  localparam int SITE_W = KIND_W + OWN_W;

  logic [CNT_W-1:0]  mc_r, mt_r;
  logic [CE_W-1:0]   ce_r, mtb_r;
  logic [MBE_W-1:0]  mbe_r;

  logic              mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [POS_W-1:0]  x_r, y_r;
  logic [RND_W-1:0]  rnd_r;

  logic              busy_r;
  logic signed [DE_W-1:0] de_r;
  logic [OWN_W-1:0]  a_r;
  dp_op_t            rd_op_r;
  logic [STEP_W-1:0] rd_step_r;
  logic [AW-1:0]     clr_addr_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic signed [DE_W-1:0] out_de_r;

  logic [CNT_W:0]    tot;
  logic              mol;
  logic [OWN_W-1:0]  tag, own_mol;
  logic [CW-1:0]     cx, cy, ox, oy, bx, by;
  logic [2:0]        dir;
  logic [1:0]        k;
  logic              use_old;
  logic [AW-1:0]     site_addr;
  logic              site_we;
  logic [AW-1:0]     site_waddr;
  logic [SITE_W-1:0] site_wdata, site_rdata;
  logic [KIND_W-1:0] rd_kind;
  logic [OWN_W-1:0]  rd_owner;
  logic              ctr_we;
  logic [2*CW-1:0]   ctr_rdata;
  logic [MBE_W-1:0]  term_mag;
  logic [P_W-1:0]    exp_tab [EXP_TABLE_DEPTH];
  logic [P_W-1:0]    p;

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    assign exp_tab[g] = exp_q16(g);
  end

  // one wrap-around step of a coordinate; sgn 1 adds k, 2 subtracts k
  function automatic logic [CW-1:0] shift_c(input logic [CW-1:0] v,
                                            input logic [1:0] sgn,
                                            input logic [1:0] kk);
    logic [CW1-1:0] s;
    s = {1'b0, v};
    if (sgn == 2'd1) begin
      s = {1'b0, v} + CW1'(kk);
      if (s >= CW1'(LATTICE_SIDE)) s = s - CW1'(LATTICE_SIDE);
    end else if (sgn == 2'd2) begin
      if (v >= CW'(kk)) s = {1'b0, v} - CW1'(kk);
      else s = {1'b0, v} + CW1'(LATTICE_SIDE) - CW1'(kk);
    end
    return CW'(s);
  endfunction

  assign tot     = {1'b0, mc_r} + {1'b0, mt_r};
  assign tag     = OWN_W'(tot + (CNT_W+1)'(1));
  assign mol     = {1'b0, idx_r} < mc_r;
  assign own_mol = OWN_W'({1'b0, idx_r} + 11'd1);
  assign cx      = CW'(x_r);
  assign cy      = CW'(y_r);
  assign ox      = ctr_rdata[2*CW-1:CW];
  assign oy      = ctr_rdata[CW-1:0];

  // footprint addressing
  always_comb begin
    use_old = 1'b0;
    dir     = DIR_CENTRE;
    k       = 2'd1;
    case (cmd.op)
      DP_OCC_RD, DP_PLACE_WR, DP_WR_NEW: dir = mol ? cmd.step[2:0] : DIR_CENTRE;
      DP_CLR_OLD: begin
        use_old = 1'b1;
        dir     = mol ? cmd.step[2:0] : DIR_CENTRE;
      end
      DP_EN_RD: begin
        use_old = cmd.step[3];
        dir     = {1'b0, cmd.step[2:1]};
        k       = (mol ? 2'd2 : 2'd1) + {1'b0, cmd.step[0]};
      end
      default: ;
    endcase
    bx = use_old ? ox : cx;
    by = use_old ? oy : cy;
    case (dir)
      DIR_UP:    bx = shift_c(bx, 2'd2, k);
      DIR_RIGHT: by = shift_c(by, 2'd1, k);
      DIR_DOWN:  bx = shift_c(bx, 2'd1, k);
      DIR_LEFT:  by = shift_c(by, 2'd2, k);
      default: ;
    endcase
    site_addr = AW'(bx) * AW'(LATTICE_SIDE) + AW'(by);
  end

  always_comb begin
    site_we    = 1'b0;
    site_waddr = site_addr;
    site_wdata = '0;
    case (cmd.op)
      DP_CLEAR: begin
        site_we    = 1'b1;
        site_waddr = clr_addr_r;
      end
      DP_CLR_OLD: site_we = 1'b1;
      DP_PLACE_WR, DP_WR_NEW: begin
        site_we = 1'b1;
        if (mol) site_wdata = {(dir == DIR_CENTRE) ? SK_CENTRE : SK_ARM, own_mol};
        else site_wdata = {SK_METAL, tag};
      end
      default: ;
    endcase
  end

  assign ctr_we = (cmd.op == DP_PLACE_WR || cmd.op == DP_WR_NEW) && cmd.step == '0;

  lmms_ram #(.WIDTH(SITE_W), .DEPTH(NSITES)) u_site_ram (
    .clk(clk), .we(site_we), .waddr(site_waddr), .wdata(site_wdata),
    .raddr(site_addr), .rdata(site_rdata)
  );

  lmms_ram #(.WIDTH(2*CW), .DEPTH(MAX_ELEMENTS)) u_centre_ram (
    .clk(clk), .we(ctr_we), .waddr(EW'(idx_r)), .wdata({cx, cy}),
    .raddr(EW'(idx_r)), .rdata(ctr_rdata)
  );

  assign rd_kind  = site_rdata[SITE_W-1:OWN_W];
  assign rd_owner = site_rdata[OWN_W-1:0];

  // energy of one arm, as a magnitude: added at the old centre, taken off at the new
  always_comb begin
    term_mag = '0;
    if (mol) begin
      if (a_r == tag) term_mag = {ce_r, 4'b0};
      else if (a_r != '0 && a_r != rd_owner) term_mag = mbe_r;
    end else if (a_r != '0 && a_r != tag && a_r == rd_owner) begin
      term_mag = {mtb_r, 4'b0};
    end
  end

  always_comb begin
    if (de_r <= 0) p = P_W'(65536);
    else if ($unsigned(de_r) < DE_W'(EXP_TABLE_DEPTH)) p = exp_tab[de_r[TW-1:0]];
    else p = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r       <= MOLECULE_COUNT_RST;
      mt_r       <= METAL_COUNT_RST;
      ce_r       <= COORD_ENERGY_RST;
      mbe_r      <= MOL_BOND_RST;
      mtb_r      <= METAL_BOND_RST;
      rd_op_r    <= DP_NOP;
      rd_step_r  <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MOLECULE_COUNT: mc_r  <= cfg_data;
          CFG_METAL_COUNT:    mt_r  <= cfg_data;
          CFG_COORD_ENERGY:   ce_r  <= cfg_data[CE_W-1:0];
          CFG_MOL_BOND:       mbe_r <= cfg_data[MBE_W-1:0];
          CFG_METAL_BOND:     mtb_r <= cfg_data[CE_W-1:0];
          default: ;
        endcase
      end
      rd_op_r   <= cmd.op;
      rd_step_r <= cmd.step;
      if (cmd.op == DP_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        mode_r <= in_mode;
        idx_r  <= in_element_index;
        x_r    <= in_pos_x;
        y_r    <= in_pos_y;
        rnd_r  <= in_random_value;
      end
      DP_WRAP: begin
        if (int'(x_r) >= LATTICE_SIDE) x_r <= x_r - POS_W'(LATTICE_SIDE);
        if (int'(y_r) >= LATTICE_SIDE) y_r <= y_r - POS_W'(LATTICE_SIDE);
      end
      DP_RESULT: begin
        out_status_r <= cmd.res;
        out_de_r     <= (cmd.res == ST_MOVED || cmd.res == ST_REJECTED) ? de_r : '0;
      end
      default: ;
    endcase

    if (cmd.op == DP_LATCH) begin
      busy_r <= 1'b0;
      de_r   <= '0;
    end else if (rd_op_r == DP_OCC_RD) begin
      if (rd_kind != SK_EMPTY) busy_r <= 1'b1;
    end else if (rd_op_r == DP_EN_RD) begin
      if (!rd_step_r[0]) a_r <= rd_owner;
      else if (rd_step_r[3]) de_r <= de_r + $signed({5'b0, term_mag});
      else de_r <= de_r - $signed({5'b0, term_mag});
    end
  end

  assign stat.clear_last = clr_addr_r == AW'(NSITES - 1);
  assign stat.wrap_done  = int'(x_r) < LATTICE_SIDE && int'(y_r) < LATTICE_SIDE;
  assign stat.bad        = {2'b0, idx_r} >= tot || int'(idx_r) >= MAX_ELEMENTS;
  assign stat.mol        = mol;
  assign stat.mode       = mode_r;
  assign stat.busy       = busy_r;
  assign stat.take       = p > ({1'b0, rnd_r} + P_W'(1));

  assign out_status       = out_status_r;
  assign out_delta_energy = out_de_r;
endmodule

[rtl/lmms_ctrl.sv]
// ----------------------------------------------------------------------------
// lmms_ctrl
// Sequencer: clearing pass, footprint check, energy sweep, write-back and
// the result handshake.
// ----------------------------------------------------------------------------
module lmms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lmms_pkg::dp_stat_t stat,
  output lmms_pkg::dp_cmd_t  cmd
);
  import lmms_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  status_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] fp_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      res_r       <= ST_PLACED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign fp_last = stat.mol ? STEP_W'(4) : '0;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = DP_NOP;
    cmd.step      = cnt_r;
    cmd.res       = res_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.op = DP_WRAP;
        if (stat.wrap_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (stat.bad) begin
          res_nxt   = ST_BAD_INDEX;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_OCC;
        end
      end
      S_OCC: begin
        cmd.op  = DP_OCC_RD;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == fp_last) state_nxt = S_OCC_WAIT;
      end
      S_OCC_WAIT: state_nxt = S_OCC_DEC;
      S_OCC_DEC: begin
        cnt_nxt = '0;
        if (stat.busy) begin
          res_nxt   = ST_OCCUPIED;
          state_nxt = S_FINISH;
        end else if (!stat.mode) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_CTR;
        end
      end
      S_PLACE: begin
        cmd.op  = DP_PLACE_WR;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == fp_last) begin
          res_nxt   = ST_PLACED;
          state_nxt = S_FINISH;
        end
      end
      S_CTR: begin
        cmd.op    = DP_CTR_RD;
        state_nxt = S_EN;
      end
      S_EN: begin
        cmd.op  = DP_EN_RD;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == '1) state_nxt = S_EN_WAIT;
      end
      S_EN_WAIT: state_nxt = S_DEC;
      S_DEC: begin
        cnt_nxt = '0;
        if (stat.take) begin
          state_nxt = S_CLR_OLD;
        end else begin
          res_nxt   = ST_REJECTED;
          state_nxt = S_FINISH;
        end
      end
      S_CLR_OLD: begin
        cmd.op  = DP_CLR_OLD;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == fp_last) begin
          cnt_nxt   = '0;
          state_nxt = S_WR_NEW;
        end
      end
      S_WR_NEW: begin
        cmd.op  = DP_WR_NEW;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == fp_last) begin
          res_nxt   = ST_MOVED;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule
